// File: design/spq_pkg.sv
// shared types and codes of the sorted priority queue
package spq_pkg;

   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] SIGN_FLIP = 32'h8000_0000;

   // input opcodes
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_MODIFY  = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // one stored entry; key is the priority with its sign bit flipped
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] key;
   } entry_type;

endpackage

// File: design/spq_ram.sv
// entry memory: one write port, one read port with registered data
module spq_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spq_pkg::entry_type  rd_data
);
   import spq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sorted_priority_queue.sv
// Sorted priority queue: entries held in ascending priority order in one memory.
// Input words arrive on req_ (opcode, value, priority); each gives one result
// word on rsp_ (status, taken entry, count, head). Insert puts the entry behind
// all entries of equal or smaller priority, extract returns the head, modify
// finds the first entry with the given value and reinserts it.
// Each memory access has a read state, then a compare-and-write state,
// since the entry memory has one read and one write port with registered read.
// An insert moves every entry behind the new one; an extract moves every entry
// after the head toward it; a modify searches, closes the gap and reinserts.
// Every word ends with a read of the head.
// One word is processed at a time; req_tready is high only while idle. The
// result sits in an output register, so the next word is taken while it waits;
// a stalled receiver holds the block at the end of that next word.
// Reset empties the queue at once (count to zero); memory contents are not
// cleared; unwritten words are read only as the head, shown as zero while empty.
module sorted_priority_queue #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], item_value[33:2], item_priority[65:34], zero pad
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], taken_value[33:2], taken_priority[65:34],
   // entry_count[72:66], head_valid[73], head_value[105:74], zero pad
   output logic [111:0] rsp_tdata
);
   import spq_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_INS_RD  = 11'b000_0000_0010,
      S_INS_CMP = 11'b000_0000_0100,
      S_EXT_RD  = 11'b000_0000_1000,
      S_EXT_CMP = 11'b000_0001_0000,
      S_REM_RD  = 11'b000_0010_0000,
      S_REM_CMP = 11'b000_0100_0000,
      S_FND_RD  = 11'b000_1000_0000,
      S_FND_CMP = 11'b001_0000_0000,
      S_HD_RD   = 11'b010_0000_0000,
      S_HD_CMP  = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              modify_ff, modify_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [WORD_W-1:0] key_ff, key_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] tv_ff, tv_in;
   logic [WORD_W-1:0] tp_ff, tp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [111:0]      rsp_data_ff, rsp_data_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic              req_fire;
   logic [6:0]        count7;
   logic [WORD_W-1:0] head_v;

   spq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign count7     = 7'(count_ff);
   assign head_v     = (count_ff == '0) ? '0 : rd_data.value;

   // sequencer: search, shift and place entries one memory word at a time
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      modify_in    = modify_ff;
      val_in       = val_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      tv_in        = tv_ff;
      tp_in        = tp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in    = req_tdata[33:2];
               key_in    = req_tdata[65:34] ^ SIGN_FLIP;
               status_in = ST_OK;
               tv_in     = '0;
               tp_in     = '0;
               modify_in = 1'b0;
               unique case (opcode_type'(req_tdata[1:0]))
                  OP_INSERT: begin
                     if (count_ff == CAP_C) begin
                        status_in = ST_FULL;
                        state_in  = S_HD_RD;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_HD_RD;
                     end else begin
                        state_in = S_EXT_RD;
                     end
                  end
                  OP_MODIFY: begin
                     idx_in    = '0;
                     modify_in = 1'b1;
                     state_in  = S_FND_RD;
                  end
                  default: begin
                     state_in = S_HD_RD;
                  end
               endcase
            end
         end
         // insert: idx is the hole, walk it toward the head
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = '{value: val_ff, key: key_ff};
               count_in = count_ff + 1'b1;
               state_in = S_HD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff - 1'b1);
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
            if (rd_data.key > key_ff) begin
               wr_data  = rd_data;
               idx_in   = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               wr_data  = '{value: val_ff, key: key_ff};
               count_in = count_ff + 1'b1;
               state_in = S_HD_RD;
            end
         end
         // extract: take the head, then close the gap
         S_EXT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_EXT_CMP;
         end
         S_EXT_CMP: begin
            tv_in    = rd_data.value;
            tp_in    = rd_data.key ^ SIGN_FLIP;
            idx_in   = CW'(1);
            state_in = S_REM_RD;
         end
         // gap closing: move entry idx down by one
         S_REM_RD: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - 1'b1;
               if (modify_ff) begin
                  idx_in   = count_ff - 1'b1;
                  state_in = S_INS_RD;
               end else begin
                  state_in = S_HD_RD;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff);
               state_in = S_REM_CMP;
            end
         end
         S_REM_CMP: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff - 1'b1);
            wr_data  = rd_data;
            idx_in   = idx_ff + 1'b1;
            state_in = S_REM_RD;
         end
         // modify: search from the head for the value
         S_FND_RD: begin
            if (idx_ff == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_HD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff);
               state_in = S_FND_CMP;
            end
         end
         S_FND_CMP: begin
            idx_in = idx_ff + 1'b1;
            if (rd_data.value == val_ff) begin
               state_in = S_REM_RD;
            end else begin
               state_in = S_FND_RD;
            end
         end
         // head read and result hand-off
         S_HD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_HD_CMP;
         end
         S_HD_CMP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, head_v, (count_ff != '0), count7,
                               tp_ff, tv_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      modify_ff   <= modify_in;
      val_ff      <= val_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      tv_ff       <= tv_in;
      tp_ff       <= tp_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: bench/tb.sv
// self-checking bench, sorted priority queue: directed and random ops vs inline queue model
module tb;
   import spq_pkg::*;

   localparam int CAP = 64;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // opcode[1:0], item_value[33:2], item_priority[65:34], zero pad
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status[1:0], taken_value[33:2], taken_priority[65:34],
   // entry_count[72:66], head_valid[73], head_value[105:74], zero pad
   logic [111:0] rsp_tdata;

   sorted_priority_queue #(.CAPACITY(CAP)) dut (.*);

   // packed from the top bit down, so the first port field is the last member
   typedef struct packed {
      logic [31:0] prio;
      logic [31:0] value;
      opcode_type  op;
   } order_t;

   typedef struct packed {
      logic [31:0] head_value;
      logic        head_valid;
      logic [6:0]  count;
      logic [31:0] taken_prio;
      logic [31:0] taken_value;
      status_type  status;
   } reply_t;

   order_t pending_orders[$];
   reply_t expected_replies[$];

   // queue model state, kept in service order
   logic [31:0] model_value[$];
   logic signed [31:0] model_prio[$];

   int errors = 0;
   int replies_seen = 0;
   int hold_cycles = 0;
   bit send_pause = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int n_ins = 0, n_ext = 0, n_mod = 0, n_full = 0, n_empty = 0, n_miss = 0;

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic void model_place(logic [31:0] v, logic signed [31:0] p);
      int pos;
      pos = 0;
      while (pos < model_prio.size() && model_prio[pos] <= p) pos++;
      model_value.insert(pos, v);
      model_prio.insert(pos, p);
   endfunction

   // predict the reply to one order and update the model
   function automatic reply_t serve_order(order_t o);
      reply_t r;
      int hit;
      r = '0;
      r.status = ST_OK;
      case (o.op)
         OP_INSERT: begin
            if (model_value.size() >= CAP) begin
               r.status = ST_FULL; n_full++;
            end else begin
               model_place(o.value, o.prio); n_ins++;
            end
         end
         OP_EXTRACT: begin
            if (model_value.size() == 0) begin
               r.status = ST_EMPTY; n_empty++;
            end else begin
               r.taken_value = model_value.pop_front();
               r.taken_prio = model_prio.pop_front();
               n_ext++;
            end
         end
         OP_MODIFY: begin
            hit = -1;
            foreach (model_value[i]) if (hit < 0 && model_value[i] == o.value) hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND; n_miss++;
            end else begin
               model_value.delete(hit);
               model_prio.delete(hit);
               model_place(o.value, o.prio); n_mod++;
            end
         end
         default: ;
      endcase
      r.count = 7'(model_value.size());
      r.head_valid = model_value.size() > 0;
      r.head_value = r.head_valid ? model_value[0] : '0;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered word
      end else begin
         if (req_tvalid) expected_replies.push_back(serve_order(order_t'(req_tdata[65:0])));
         if (send_pause && expected_replies.size() > 0) begin
            req_tvalid <= 1'b0;
         end else if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_orders.size() > 0 && !(req_tvalid && send_pause)) begin
            req_tdata <= {6'b0, pending_orders.pop_front()};
            req_tvalid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      reply_t got, exp;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = reply_t'(rsp_tdata[105:0]);
            replies_seen++;
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply %h", $time, got);
               errors++;
            end else begin
               exp = expected_replies.pop_front();
               if (got.status !== exp.status)
                  $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
               if (got.taken_value !== exp.taken_value)
                  $display("%0t: taken value exp %h got %h", $time, exp.taken_value,
                           got.taken_value);
               if (got.taken_prio !== exp.taken_prio)
                  $display("%0t: taken priority exp %h got %h", $time, exp.taken_prio,
                           got.taken_prio);
               if (got.count !== exp.count)
                  $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
               if (got.head_valid !== exp.head_valid)
                  $display("%0t: head valid exp %b got %b", $time, exp.head_valid,
                           got.head_valid);
               if (got.head_value !== exp.head_value)
                  $display("%0t: head value exp %h got %h", $time, exp.head_value,
                           got.head_value);
               if (got !== exp) errors++;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   task automatic add_order(opcode_type op, logic [31:0] v, logic [31:0] p);
      pending_orders.push_back('{op: op, value: v, prio: p});
   endtask

   task automatic wait_drained();
      while (pending_orders.size() > 0 || req_tvalid || expected_replies.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [31:0] v, p;
      int mode, fill;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, equal priorities, opcode 3
      add_order(OP_EXTRACT, 32'h0, 32'h0);
      add_order(OP_MODIFY, 32'h5, 32'h1);
      add_order(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
      add_order(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
      add_order(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
      add_order(OP_INSERT, 32'h1, 32'h5);
      add_order(OP_INSERT, 32'h2, 32'h5);
      add_order(OP_INSERT, 32'h1, 32'hffff_ffff);
      add_order(OP_MODIFY, 32'h1, 32'h5);
      add_order(OP_MODIFY, 32'h7fff_ffff, 32'h8000_0000);
      add_order(OP_MODIFY, 32'h99, 32'h0);
      add_order(OP_NONE, 32'h0, 32'h0);
      repeat (7) add_order(OP_EXTRACT, 32'h0, 32'h0);
      wait_drained();

      // fill up while the receiver holds off, so the input stalls
      for (int i = 0; i < CAP + 3; i++) add_order(OP_INSERT, $urandom(), $urandom_range(0, 7));
      hold_cycles = 400;
      wait_drained();
      for (int i = 0; i < CAP + 2; i++) add_order(OP_EXTRACT, 32'h0, 32'h0);
      wait_drained();

      // random phases of varying fill levels
      for (int blk = 0; blk < 32; blk++) begin
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 50; i++) begin
            v = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 15)) : pick_word();
            p = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 7)) : pick_word();
            fill = $urandom_range(0, 99);
            if (fill < (mode == 0 ? 60 : mode == 1 ? 30 : 45)) add_order(OP_INSERT, v, p);
            else if (fill < 80) add_order(OP_EXTRACT, v, p);
            else if (fill < 98) add_order(OP_MODIFY, v, p);
            else add_order(OP_NONE, v, p);
         end
         if (blk == 10) begin
            // sender waits for every reply before going on
            send_pause = 1;
            wait_drained();
            send_pause = 0;
         end
      end
      wait_drained();
      repeat (300) @(posedge clock);
      if (expected_replies.size() > 0) errors++;

      $display("replies %0d: inserts %0d extracts %0d modifies %0d", replies_seen, n_ins,
               n_ext, n_mod);
      $display("rejected full %0d, empty extracts %0d, modify misses %0d", n_full, n_empty,
               n_miss);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
